// ----- hdl/rlpe_pkg.sv -----
// ----------------------------------------------------------------------------
// rlpe_pkg: shared types and constants of the line position block
// Sensor count, calibration widths, register indexes, smoothing
// coefficients and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlpe_pkg;

  // Number of sensors in one frame and the width of a sensor index.
  localparam int SENSOR_COUNT = 4;
  localparam int SENSOR_IDX_W = 2;

  // Field widths fixed by the frame format.
  localparam int RAW_W   = 32;
  localparam int COUNT_W = 20;
  localparam int REF_W   = 21;
  localparam int MASK_W  = 4;

  // Configuration register map.
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_WHITE_BASE = 0;
  localparam int CFG_BLACK_BASE = 4;
  localparam int CFG_REG_COUNT  = 8;

  // Reset values of the white calibration counts.
  localparam logic [REF_W-1:0] WHITE_RESET [SENSOR_COUNT] = '{
    21'd5900, 21'd8500, 21'd8400, 21'd12000
  };

  // Position weights, outside left to outside right.
  localparam logic signed [2:0] WEIGHT [SENSOR_COUNT] = '{
    -3'sd3, -3'sd1, 3'sd1, 3'sd3
  };

  // Smoothing coefficients in Q0.16 and the rounding term.
  localparam int COEF_W    = 17;
  localparam int EMA_SHIFT = 16;
  localparam logic signed [COEF_W-1:0] ALPHA_Q16     = 17'sd19661;
  localparam logic signed [COEF_W-1:0] ONE_MINUS_Q16 = 17'sd45875;
  localparam int ROUND_HALF = 32768;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_DIV,
    ST_ACC,
    ST_EMA_A,
    ST_EMA_B,
    ST_EMA_C,
    ST_OUT
  } rlpe_state_t;

endpackage

`default_nettype wire

// ----- hdl/rlpe_ifs.sv -----
// ----------------------------------------------------------------------------
// rlpe channel interfaces
// Valid/ready channels for sensor frames, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Sensor frame channel.
interface rlpe_in_if
  import rlpe_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  raw_0;
  logic [RAW_W-1:0]  raw_1;
  logic [RAW_W-1:0]  raw_2;
  logic [RAW_W-1:0]  raw_3;
  logic [MASK_W-1:0] fresh_mask;

  modport source (output valid, raw_0, raw_1, raw_2, raw_3, fresh_mask, input ready);
  modport sink   (input valid, raw_0, raw_1, raw_2, raw_3, fresh_mask, output ready);
endinterface

// Result channel; widths follow the number of fraction bits.
interface rlpe_out_if #(
  parameter int FRACTION_BITS = 16
);
  logic                            valid;
  logic                            ready;
  logic [FRACTION_BITS:0]          norm_0;
  logic [FRACTION_BITS:0]          norm_1;
  logic [FRACTION_BITS:0]          norm_2;
  logic [FRACTION_BITS:0]          norm_3;
  logic signed [FRACTION_BITS+3:0] line_error;

  modport source (output valid, norm_0, norm_1, norm_2, norm_3, line_error, input ready);
  modport sink   (input valid, norm_0, norm_1, norm_2, norm_3, line_error, output ready);
endinterface

// Register write channel.
interface rlpe_cfg_if
  import rlpe_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [REF_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/reflectance_line_position_ema.sv -----
// ----------------------------------------------------------------------------
// reflectance_line_position_ema: line position from four reflectance sensors
// Turns raw countdowns into elapsed counts, normalizes each against its
// calibration with a shared serial divider, forms the weighted position
// and smooths it with an exponential moving average.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Payload
//  in_s     in   valid/ready   raw_0..raw_3 (32b), fresh_mask (4b)
//  out_s    out  valid/ready   norm_0..norm_3 (F+1 b), line_error (F+4 b, signed)
//  cfg_s    in   valid/ready   index (4b), data (21b); ready is always high
//
//  A request is accepted in the idle state, then per sensor a compare
//  state, restoring division steps (skipped when the count clamps) and an
//  accumulate state, then the two smoothing products in the shared
//  multiplier, a rounding state and an output state that waits for the
//  sink. A single divider serves all sensors, a single multiplier both
//  products. Widths above use F = FRACTION_BITS.
//  Reset is synchronous; it clears counts, the average and the sequencer.
//  in_s.ready is low from acceptance until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module reflectance_line_position_ema
  import rlpe_pkg::*;
#(
  parameter int TIMEOUT_LOOPS = 1048575,
  parameter int FRACTION_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  rlpe_in_if.sink     in_s,
  rlpe_out_if.source  out_s,
  rlpe_cfg_if.sink    cfg_s
);

  localparam int NORM_W  = FRACTION_BITS + 1;
  localparam int SUM_W   = FRACTION_BITS + 4;
  localparam int PROD_W  = SUM_W + COEF_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int BIT_W   = $clog2(FRACTION_BITS);
  localparam int REM_W   = REF_W + 1;

  localparam logic [COUNT_W-1:0] TIMEOUT_COUNT = COUNT_W'(TIMEOUT_LOOPS);
  localparam logic [REF_W-1:0]   BLACK_RESET   = REF_W'(TIMEOUT_LOOPS + 1);
  localparam logic [NORM_W-1:0]  NORM_ONE      = NORM_W'(1) << FRACTION_BITS;
  localparam logic [BIT_W-1:0]   BIT_LAST      = BIT_W'(FRACTION_BITS - 1);
  localparam logic [SENSOR_IDX_W-1:0] IDX_LAST = SENSOR_IDX_W'(SENSOR_COUNT - 1);
  localparam logic signed [ACC_W-1:0] ROUND_TERM = ACC_W'(ROUND_HALF);

  // Elapsed count for one fresh raw value.
  function automatic logic [COUNT_W-1:0] count_from_raw(input logic [RAW_W-1:0] raw);
    logic [COUNT_W-1:0] cnt;
    if (raw == '0 || raw == '1) begin
      cnt = TIMEOUT_COUNT;
    end else if (raw > RAW_W'(TIMEOUT_LOOPS)) begin
      cnt = '0;
    end else begin
      cnt = COUNT_W'(RAW_W'(TIMEOUT_LOOPS) - raw);
    end
    return cnt;
  endfunction

  // Registers.
  rlpe_state_t              state_r, state_nxt;
  logic [COUNT_W-1:0]       elapsed_r [SENSOR_COUNT];
  logic [COUNT_W-1:0]       elapsed_nxt [SENSOR_COUNT];
  logic [REF_W-1:0]         white_r [SENSOR_COUNT];
  logic [REF_W-1:0]         white_nxt [SENSOR_COUNT];
  logic [REF_W-1:0]         black_r [SENSOR_COUNT];
  logic [REF_W-1:0]         black_nxt [SENSOR_COUNT];
  logic [NORM_W-1:0]        norm_r [SENSOR_COUNT];
  logic [NORM_W-1:0]        norm_nxt [SENSOR_COUNT];
  logic [NORM_W-1:0]        cur_norm_r, cur_norm_nxt;
  logic [SENSOR_IDX_W-1:0]  idx_r, idx_nxt;
  logic [BIT_W-1:0]         bit_r, bit_nxt;
  logic [REF_W-1:0]         rem_r, rem_nxt;
  logic [REF_W-1:0]         den_r, den_nxt;
  logic [FRACTION_BITS-1:0] quo_r, quo_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [SUM_W-1:0]  smooth_r, smooth_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  // Datapath signals.
  logic                     in_take;
  logic                     out_take;
  logic [RAW_W-1:0]         raw_arr [SENSOR_COUNT];
  logic [REF_W-1:0]         cnt_ext;
  logic [REF_W-1:0]         white_sel;
  logic [REF_W-1:0]         black_sel;
  logic                     below_white;
  logic                     above_black;
  logic [REM_W-1:0]         rem_shift;
  logic                     div_fits;
  logic [REM_W-1:0]         rem_sub;
  logic signed [SUM_W-1:0]  term;
  logic signed [PROD_W-1:0] mul_a;
  logic signed [PROD_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  acc_fin;

  assign raw_arr[0] = in_s.raw_0;
  assign raw_arr[1] = in_s.raw_1;
  assign raw_arr[2] = in_s.raw_2;
  assign raw_arr[3] = in_s.raw_3;

  assign in_take  = in_s.valid && in_s.ready;
  assign out_take = out_s.valid && out_s.ready;

  // Calibration compare for the sensor in work.
  assign cnt_ext     = {1'b0, elapsed_r[idx_r]};
  assign white_sel   = white_r[idx_r];
  assign black_sel   = black_r[idx_r];
  assign below_white = (cnt_ext <= white_sel);
  assign above_black = (cnt_ext >= black_sel);

  // One restoring division step.
  assign rem_shift = {rem_r, 1'b0};
  assign div_fits  = (rem_shift >= {1'b0, den_r});
  assign rem_sub   = rem_shift - {1'b0, den_r};

  // Weighted contribution of the current darkness value.
  assign term = SUM_W'(signed'({1'b0, cur_norm_r})) * SUM_W'(WEIGHT[idx_r]);

  // Shared multiplier for the two smoothing products.
  assign mul_a   = (state_r == ST_EMA_A) ? PROD_W'(ALPHA_Q16) : PROD_W'(ONE_MINUS_Q16);
  assign mul_b   = (state_r == ST_EMA_A) ? PROD_W'(sum_r) : PROD_W'(smooth_r);
  assign mul_p   = mul_a * mul_b;
  assign acc_fin = acc_r + ACC_W'(prod_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (below_white || above_black) state_nxt = ST_ACC;
        else state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (bit_r == BIT_LAST) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (idx_r == IDX_LAST) state_nxt = ST_EMA_A;
        else state_nxt = ST_CLAMP;
      end
      ST_EMA_A: state_nxt = ST_EMA_B;
      ST_EMA_B: state_nxt = ST_EMA_C;
      ST_EMA_C: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs and result payload.
  always_comb begin
    in_s.ready       = (state_r == ST_IDLE);
    cfg_s.ready      = 1'b1;
    out_s.valid      = (state_r == ST_OUT);
    out_s.norm_0     = norm_r[0];
    out_s.norm_1     = norm_r[1];
    out_s.norm_2     = norm_r[2];
    out_s.norm_3     = norm_r[3];
    out_s.line_error = smooth_r;
  end

  // Datapath next values.
  always_comb begin
    elapsed_nxt  = elapsed_r;
    white_nxt    = white_r;
    black_nxt    = black_r;
    norm_nxt     = norm_r;
    cur_norm_nxt = cur_norm_r;
    idx_nxt      = idx_r;
    bit_nxt      = bit_r;
    rem_nxt      = rem_r;
    den_nxt      = den_r;
    quo_nxt      = quo_r;
    sum_nxt      = sum_r;
    smooth_nxt   = smooth_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;

    // Register writes; indexes past the map are dropped.
    if (cfg_s.valid) begin
      if (cfg_s.index < CFG_INDEX_W'(CFG_BLACK_BASE)) begin
        white_nxt[cfg_s.index[SENSOR_IDX_W-1:0]] = cfg_s.data;
      end else if (cfg_s.index < CFG_INDEX_W'(CFG_REG_COUNT)) begin
        black_nxt[cfg_s.index[SENSOR_IDX_W-1:0]] = cfg_s.data;
      end
    end

    case (state_r)
      ST_IDLE: begin
        // Fresh sensors take a new count; stale ones keep theirs.
        if (in_take) begin
          for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (in_s.fresh_mask[i]) elapsed_nxt[i] = count_from_raw(raw_arr[i]);
          end
          idx_nxt = '0;
          sum_nxt = '0;
        end
      end
      ST_CLAMP: begin
        // Clamp at the calibration ends or set up the division.
        if (below_white) begin
          cur_norm_nxt = '0;
        end else if (above_black) begin
          cur_norm_nxt = NORM_ONE;
        end else begin
          rem_nxt = cnt_ext - white_sel;
          den_nxt = black_sel - white_sel;
          quo_nxt = '0;
          bit_nxt = '0;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle; the remainder stays below the divisor.
        rem_nxt = div_fits ? rem_sub[REF_W-1:0] : rem_shift[REF_W-1:0];
        quo_nxt = {quo_r[FRACTION_BITS-2:0], div_fits};
        bit_nxt = bit_r + BIT_W'(1);
        if (bit_r == BIT_LAST) begin
          cur_norm_nxt = {1'b0, quo_r[FRACTION_BITS-2:0], div_fits};
        end
      end
      ST_ACC: begin
        norm_nxt[idx_r] = cur_norm_r;
        sum_nxt         = sum_r + term;
        idx_nxt         = idx_r + SENSOR_IDX_W'(1);
      end
      ST_EMA_A: begin
        prod_nxt = mul_p;
      end
      ST_EMA_B: begin
        acc_nxt  = ACC_W'(prod_r) + ROUND_TERM;
        prod_nxt = mul_p;
      end
      ST_EMA_C: begin
        // Round to nearest with ties upward and drop the Q0.16 scale.
        smooth_nxt = SUM_W'(acc_fin >>> EMA_SHIFT);
      end
      default: begin
      end
    endcase
  end

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      smooth_r <= '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        elapsed_r[i] <= '0;
        white_r[i]   <= WHITE_RESET[i];
        black_r[i]   <= BLACK_RESET;
      end
    end else begin
      state_r   <= state_nxt;
      smooth_r  <= smooth_nxt;
      elapsed_r <= elapsed_nxt;
      white_r   <= white_nxt;
      black_r   <= black_nxt;
    end
    norm_r     <= norm_nxt;
    cur_norm_r <= cur_norm_nxt;
    idx_r      <= idx_nxt;
    bit_r      <= bit_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    quo_r      <= quo_nxt;
    sum_r      <= sum_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
  end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the reflectance line position block
// Feeds sensor frames through the request channel with random gaps on both
// sides, predicts every reading (elapsed counts, calibrated darkness, weighted
// position and smoothed error) in the bench, and compares each returned
// reading field by field. Calibration is reloaded between phases while the
// block is idle, covering the reset values, degenerate and crossed settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rlpe_pkg::*;

  // Bench constants.
  localparam int FRAC_BITS = 16;
  localparam int NORM_W = FRAC_BITS + 1;
  localparam int ERR_W = FRAC_BITS + 4;
  localparam logic [RAW_W-1:0] TIMEOUT_COUNT = 32'd1048575;
  localparam logic [REF_W-1:0] FULL_SCALE = 21'd1048576;
  localparam logic [NORM_W-1:0] NORM_ONE = 17'd65536;
  localparam longint SMOOTH_GAIN = 19661;
  localparam longint SMOOTH_KEEP = 45875;
  localparam longint SMOOTH_ROUND = 32768;
  localparam longint POS_WEIGHT [SENSOR_COUNT] = '{-3, -1, 1, 3};
  localparam logic [REF_W-1:0] WHITE_AT_RESET [SENSOR_COUNT] = '{
    21'd5900, 21'd8500, 21'd8400, 21'd12000
  };
  localparam int RESET_CYCLES = 9;
  localparam int SINK_HOLDOFF = 400;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_ITEMS = 93;

  // Calibration settings loaded between phases.
  typedef enum logic [2:0] {
    CAL_KEEP,
    CAL_RESET_VALUES,
    CAL_ALL_ZERO,
    CAL_WHITE_TOP,
    CAL_FULL_SPAN,
    CAL_CROSSED,
    CAL_RANDOM
  } cal_set_t;

  localparam cal_set_t PHASE_CAL [PHASE_COUNT] = '{
    CAL_RANDOM, CAL_ALL_ZERO, CAL_RANDOM, CAL_RESET_VALUES, CAL_RANDOM,
    CAL_FULL_SPAN, CAL_RANDOM, CAL_CROSSED, CAL_RANDOM, CAL_RANDOM
  };

  typedef struct packed {
    logic [SENSOR_COUNT-1:0][RAW_W-1:0] raw;
    logic [MASK_W-1:0]                  fresh_mask;
  } frame_t;

  typedef struct packed {
    logic [SENSOR_COUNT-1:0][NORM_W-1:0] norm;
    logic signed [ERR_W-1:0]             line_error;
  } reading_t;

  typedef struct packed {
    cal_set_t cal;
    frame_t   frame;
    logic     typed;
    reading_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rlpe_in_if                             in_ch ();
  rlpe_out_if #(.FRACTION_BITS(FRAC_BITS)) out_ch ();
  rlpe_cfg_if                            cfg_ch ();

  reflectance_line_position_ema #(
    .TIMEOUT_LOOPS(1048575),
    .FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_ch),
    .out_s(out_ch),
    .cfg_s(cfg_ch)
  );

  // Bench copy of the block state and calibration.
  logic [REF_W-1:0]   white_cal [SENSOR_COUNT] = WHITE_AT_RESET;
  logic [REF_W-1:0]   black_cal [SENSOR_COUNT] = '{default: FULL_SCALE};
  logic [COUNT_W-1:0] elapsed_now [SENSOR_COUNT] = '{default: '0};
  longint             ema_err = 0;

  reading_t    expected_readings [$];
  stim_row_t   stim_rows [$];
  int unsigned sent_count = 0;
  int unsigned mismatch_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A fresh raw value becomes an elapsed count; timeout codes saturate.
  function automatic logic [COUNT_W-1:0] elapsed_from_raw(logic [RAW_W-1:0] raw);
    if (raw == '0 || raw == '1) return TIMEOUT_COUNT[COUNT_W-1:0];
    if (raw > TIMEOUT_COUNT) return '0;
    return COUNT_W'(TIMEOUT_COUNT - raw);
  endfunction

  // Darkness in Q0.16; white is tested before black.
  function automatic logic [NORM_W-1:0] darkness(logic [COUNT_W-1:0] cnt,
                                                 logic [REF_W-1:0] white,
                                                 logic [REF_W-1:0] black);
    longint unsigned num;
    longint unsigned den;
    if (cnt <= white) return '0;
    if (cnt >= black) return NORM_ONE;
    num = (64'(cnt) - 64'(white)) << FRAC_BITS;
    den = 64'(black) - 64'(white);
    return NORM_W'(num / den);
  endfunction

  // Next reading for an accepted frame; updates the bench state.
  function automatic reading_t predict_reading(frame_t f);
    reading_t r;
    longint   acc;
    longint   t;
    int       i;
    acc = 0;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      if (f.fresh_mask[i]) elapsed_now[i] = elapsed_from_raw(f.raw[i]);
      r.norm[i] = darkness(elapsed_now[i], white_cal[i], black_cal[i]);
      acc += POS_WEIGHT[i] * longint'(r.norm[i]);
    end
    t = SMOOTH_GAIN * acc + SMOOTH_KEEP * ema_err + SMOOTH_ROUND;
    ema_err = t >>> 16;
    r.line_error = ERR_W'(ema_err);
    return r;
  endfunction

  // Row of the directed table.
  function automatic stim_row_t stim_row(cal_set_t cal, logic [MASK_W-1:0] mask,
                                         logic [RAW_W-1:0] r0, logic [RAW_W-1:0] r1,
                                         logic [RAW_W-1:0] r2, logic [RAW_W-1:0] r3,
                                         logic typed, int n0, int n1, int n2, int n3,
                                         int err);
    stim_row_t s;
    s.cal = cal;
    s.frame.raw[0] = r0;
    s.frame.raw[1] = r1;
    s.frame.raw[2] = r2;
    s.frame.raw[3] = r3;
    s.frame.fresh_mask = mask;
    s.typed = typed;
    s.want.norm[0] = NORM_W'(n0);
    s.want.norm[1] = NORM_W'(n1);
    s.want.norm[2] = NORM_W'(n2);
    s.want.norm[3] = NORM_W'(n3);
    s.want.line_error = ERR_W'(err);
    return s;
  endfunction

  // Mostly short gaps, a few long ones, none in calm windows.
  function automatic int unsigned idle_cycles(logic calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(21, 120);
  endfunction

  // Raw countdown that yields the given elapsed count, kept off the timeout codes.
  function automatic logic [RAW_W-1:0] raw_for_count(int unsigned c);
    if (c < 1) c = 1;
    if (c > TIMEOUT_COUNT - 1) c = TIMEOUT_COUNT - 1;
    return TIMEOUT_COUNT - c;
  endfunction

  // Random frame; steady frames use only saturating values.
  function automatic frame_t random_frame(logic steady);
    frame_t      f;
    int unsigned lo;
    int unsigned hi;
    int          i;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      lo = (white_cal[i] < black_cal[i]) ? white_cal[i] : black_cal[i];
      hi = (white_cal[i] < black_cal[i]) ? black_cal[i] : white_cal[i];
      if (steady) begin
        case ($urandom_range(0, 3))
          0: f.raw[i] = '0;
          1: f.raw[i] = '1;
          2: f.raw[i] = TIMEOUT_COUNT;
          default: f.raw[i] = 32'hF000_0000;
        endcase
      end else begin
        case ($urandom_range(0, 19))
          0: f.raw[i] = '0;
          1: f.raw[i] = '1;
          2: f.raw[i] = $urandom_range(TIMEOUT_COUNT + 1, 32'hFFFF_FFFE);
          3: f.raw[i] = $urandom();
          4: f.raw[i] = TIMEOUT_COUNT;
          5: f.raw[i] = 32'd1;
          6: f.raw[i] = raw_for_count(white_cal[i]);
          7: f.raw[i] = raw_for_count(black_cal[i]);
          8: f.raw[i] = raw_for_count(white_cal[i] + 1);
          default: f.raw[i] = raw_for_count($urandom_range(lo > 64 ? lo - 64 : 0, hi + 64));
        endcase
      end
    end
    if (steady || $urandom_range(0, 9) < 6) f.fresh_mask = '1;
    else f.fresh_mask = MASK_W'($urandom_range(0, 15));
    return f;
  endfunction

  // One register write request; valid is left high for the caller to drop.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REF_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < CFG_BLACK_BASE) white_cal[idx - CFG_WHITE_BASE] = val;
    else if (idx < CFG_REG_COUNT) black_cal[idx - CFG_BLACK_BASE] = val;
  endtask

  // Writes all calibration registers plus one stray index above the map.
  task automatic load_calibration(input cal_set_t sel);
    logic [REF_W-1:0] w [SENSOR_COUNT];
    logic [REF_W-1:0] b [SENSOR_COUNT];
    int unsigned      r;
    int               i;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      case (sel)
        CAL_RESET_VALUES: begin
          w[i] = WHITE_AT_RESET[i];
          b[i] = FULL_SCALE;
        end
        CAL_ALL_ZERO: begin
          w[i] = '0;
          b[i] = '0;
        end
        CAL_WHITE_TOP: begin
          w[i] = FULL_SCALE;
          b[i] = '0;
        end
        CAL_FULL_SPAN: begin
          w[i] = '0;
          b[i] = FULL_SCALE;
        end
        CAL_CROSSED: begin
          w[i] = 21'd600000;
          b[i] = 21'd300000;
        end
        default: begin
          w[i] = ($urandom_range(0, 9) == 0) ? FULL_SCALE : REF_W'($urandom_range(0, 400000));
          r = $urandom_range(0, 9);
          if (r == 0) b[i] = REF_W'($urandom_range(0, w[i]));
          else if (r == 1 || w[i] + 600000 > FULL_SCALE) b[i] = FULL_SCALE;
          else b[i] = REF_W'(w[i] + $urandom_range(1, 600000));
        end
      endcase
    end
    write_reg(CFG_INDEX_W'($urandom_range(CFG_REG_COUNT, 15)), REF_W'($urandom_range(0, 1048576)));
    for (i = 0; i < SENSOR_COUNT; i++) begin
      write_reg(CFG_INDEX_W'(CFG_WHITE_BASE + i), w[i]);
      write_reg(CFG_INDEX_W'(CFG_BLACK_BASE + i), b[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Offers one frame, records its expected reading once accepted.
  task automatic send_frame(input frame_t f, input logic typed, input reading_t want);
    reading_t    predicted;
    int unsigned gap;
    in_ch.valid      <= 1'b1;
    in_ch.raw_0      <= f.raw[0];
    in_ch.raw_1      <= f.raw[1];
    in_ch.raw_2      <= f.raw[2];
    in_ch.raw_3      <= f.raw[3];
    in_ch.fresh_mask <= f.fresh_mask;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_reading(f);
    expected_readings.push_back(typed ? want : predicted);
    sent_count++;
    gap = idle_cycles(((sent_count / 64) % 5) == 2);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic await_quiet();
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // Request source: directed table, then random phases.
  initial begin : stimulus
    frame_t      f;
    logic        steady;
    int unsigned run_left;
    int          k;
    int          phase;
    int          n;
    in_ch.valid      <= 1'b0;
    in_ch.raw_0      <= '0;
    in_ch.raw_1      <= '0;
    in_ch.raw_2      <= '0;
    in_ch.raw_3      <= '0;
    in_ch.fresh_mask <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    rst_n            <= 1'b0;
    stim_rows = '{
      // Reset state: counts and average start at zero.
      stim_row(CAL_KEEP, 4'h0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0),
      // Zero calibration: any nonzero count reads as full darkness.
      stim_row(CAL_ALL_ZERO, 4'hF, 0, 0, 0, 0, 1'b1, 65536, 65536, 65536, 65536, 0),
      stim_row(CAL_KEEP, 4'hF, '1, '1, '1, '1, 1'b1, 65536, 65536, 65536, 65536, 0),
      // Raw above the start value means nothing elapsed.
      stim_row(CAL_KEEP, 4'hF, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000,
               1'b1, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'hF, TIMEOUT_COUNT, TIMEOUT_COUNT, TIMEOUT_COUNT, TIMEOUT_COUNT,
               1'b1, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'hF, 1, 1, 1, 1, 1'b1, 65536, 65536, 65536, 65536, 0),
      // Stale right outside sensor keeps its count.
      stim_row(CAL_KEEP, 4'b0111, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_BEEF,
               1'b1, 0, 0, 0, 65536, 58983),
      stim_row(CAL_KEEP, 4'b1000, 0, 0, 0, 32'hFFFF_FFFE, 1'b0, 0, 0, 0, 0, 0),
      // Full left and full right positions.
      stim_row(CAL_KEEP, 4'hF, 0, 0, 32'h8000_0000, 32'h8000_0000, 1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'h0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'hF, 32'h8000_0000, 32'h8000_0000, '1, '1, 1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'hF, 32'h8000_0000, 32'h8000_0000, '1, '1, 1'b0, 0, 0, 0, 0, 0),
      // Reset calibration: count at white, just above white, near black.
      stim_row(CAL_RESET_VALUES, 4'hF, TIMEOUT_COUNT - 32'd5900, TIMEOUT_COUNT - 32'd8501,
               0, 1, 1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'b0101, 32'h0001_2345, 32'h0000_0007, 32'h000F_0000, 32'h0000_0009,
               1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_FULL_SPAN, 4'hF, 0, TIMEOUT_COUNT, 32'd524288, 32'h7FFF_FFFF,
               1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'b1010, 32'h0000_0003, 32'h0005_5555, 32'h0000_0004, 32'h000A_AAAA,
               1'b0, 0, 0, 0, 0, 0),
      // Black below white: counts split on white alone.
      stim_row(CAL_CROSSED, 4'hF, TIMEOUT_COUNT - 32'd600000, TIMEOUT_COUNT - 32'd600001,
               TIMEOUT_COUNT - 32'd300000, 0, 1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'b0011, TIMEOUT_COUNT - 32'd300001, '1, 0, 0, 1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_WHITE_TOP, 4'hF, 0, 1, 2, 3, 1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'h0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_RANDOM, 4'hF, 32'h000C_3500, 32'h0008_0000, 32'h0004_0000, 32'h0001_0000,
               1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'b1001, 32'h000F_FF00, 0, 0, 32'h0000_0100, 1'b0, 0, 0, 0, 0, 0),
      stim_row(CAL_KEEP, 4'hF, 32'h5A5A_5A5A, 32'h000A_5A5A, 32'h0005_A5A5, 32'hA5A5_A5A5,
               1'b0, 0, 0, 0, 0, 0)
    };
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; calibration changes only with the pipe empty.
    for (k = 0; k < stim_rows.size(); k++) begin
      if (stim_rows[k].cal != CAL_KEEP) begin
        in_ch.valid <= 1'b0;
        await_quiet();
        load_calibration(stim_rows[k].cal);
      end
      send_frame(stim_rows[k].frame, stim_rows[k].typed, stim_rows[k].want);
    end

    // Random phases; saturating phases hold frames for long runs.
    run_left = 0;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      in_ch.valid <= 1'b0;
      await_quiet();
      load_calibration(PHASE_CAL[phase]);
      steady = (PHASE_CAL[phase] == CAL_ALL_ZERO) || (PHASE_CAL[phase] == CAL_FULL_SPAN);
      run_left = 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          f = random_frame(steady);
          run_left = steady ? $urandom_range(30, 60) : 1;
        end
        run_left--;
        send_frame(f, 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    await_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Result sink with random stalls and two long hold-offs.
  initial begin : result_sink
    int unsigned taken;
    int unsigned stall;
    taken = 0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken == 300 || taken == 700) stall = SINK_HOLDOFF;
      else stall = idle_cycles(((taken / 64) % 5) == 4);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // Compare every returned reading with the oldest expectation.
  always @(posedge clk) begin : reading_check
    reading_t got;
    reading_t want;
    int       i;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.norm[0]    = out_ch.norm_0;
      got.norm[1]    = out_ch.norm_1;
      got.norm[2]    = out_ch.norm_2;
      got.norm[3]    = out_ch.norm_3;
      got.line_error = out_ch.line_error;
      if (expected_readings.size() == 0) begin
        mismatch_count++;
        $display("%0t: reading with no request outstanding, line_error %0d",
                 $time, $signed(got.line_error));
      end else begin
        want = expected_readings.pop_front();
        for (i = 0; i < SENSOR_COUNT; i++) begin
          if (got.norm[i] !== want.norm[i]) begin
            mismatch_count++;
            $display("%0t: norm_%0d expected %0d, got %0d",
                     $time, i, want.norm[i], got.norm[i]);
          end
        end
        if (got.line_error !== want.line_error) begin
          mismatch_count++;
          $display("%0t: line_error expected %0d, got %0d",
                   $time, $signed(want.line_error), $signed(got.line_error));
        end
      end
    end
  end

  // Run limit, several times the slowest legal run.
  initial begin : run_limit
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rlpe_pkg.sv
hdl/rlpe_ifs.sv
hdl/reflectance_line_position_ema.sv
test/tb_top.sv
